FILE: sv/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared constants and types for the polyline time slice block.
// ----------------------------------------------------------------------------
package pts_pkg;

	localparam int unsigned MAX_POINTS_DEF = 1024;

	// Register byte addresses
	localparam int unsigned ADDR_W = 4;
	localparam logic [ADDR_W-1:0] REG_BEGIN = 4'h0;
	localparam logic [ADDR_W-1:0] REG_END   = 4'h4;
	localparam logic [ADDR_W-1:0] REG_SPEED = 4'h8;

	localparam logic [31:0] SPEED_RST = 32'h0001_0000;
	localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;

	// Serial unit widths
	localparam int unsigned MUL_W = 33;
	localparam int unsigned DIV_W = 64;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHK,
		ST_SQ_GO,
		ST_SQ_WT,
		ST_RT_GO,
		ST_RT_WT,
		ST_TT_GO,
		ST_TT_WT,
		ST_PREV,
		ST_BEG,
		ST_FR_GO,
		ST_FR_WT,
		ST_LP_GO,
		ST_LP_WT,
		ST_CUT,
		ST_END,
		ST_UPD,
		ST_LAST
	} st_t;

endpackage

FILE: sv/pts_mul.sv
// ----------------------------------------------------------------------------
// pts_mul
// Bit-serial unsigned multiplier: one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pts_mul #(
	parameter int unsigned W = pts_pkg::MUL_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic           done,
	output logic [2*W-1:0] prod
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  a_q;
	logic [W-1:0]  hi_q;
	logic [W-1:0]  lo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    sum;

	// add the multiplicand when the low bit is set
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift the partial product right one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[W:1];
			lo_q <= {sum[0], lo_q[W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

FILE: sv/pts_sqrt.sv
// ----------------------------------------------------------------------------
// pts_sqrt
// Digit-serial integer square root: one root bit per cycle for a 32-bit root.
// ----------------------------------------------------------------------------
module pts_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] n,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] n_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] trem;
	logic [35:0] trial;
	logic        fit;

	// bring down two bits and try a one
	assign trem  = {rem_q, n_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fit   = trem >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= n;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q    <= {n_q[61:0], 2'b00};
			rem_q  <= fit ? 34'(trem - trial) : trem[33:0];
			root_q <= {root_q[30:0], fit};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: sv/pts_div.sv
// ----------------------------------------------------------------------------
// pts_div
// Restoring divider: one quotient bit per cycle, 64-bit dividend, 32-bit divisor.
// ----------------------------------------------------------------------------
module pts_div #(
	parameter int unsigned W = pts_pkg::DIV_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [31:0]  divisor,
	output logic         done,
	output logic [W-1:0] quot
);
	localparam int unsigned CW = $clog2(W + 1);

	logic [W-1:0]  dd_q;
	logic [31:0]   dv_q;
	logic [31:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [32:0]   trem;
	logic          fit;

	// shift in the next dividend bit and compare
	assign trem = {rem_q, dd_q[W-1]};
	assign fit  = trem >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits fill the dividend register from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dd_q  <= dividend;
			dv_q  <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fit ? 32'(trem - {1'b0, dv_q}) : trem[31:0];
			dd_q  <= {dd_q[W-2:0], fit};
		end
	end

	assign done = done_q;
	assign quot = dd_q;

endmodule

FILE: sv/polyline_time_slice.sv
// ----------------------------------------------------------------------------
// polyline_time_slice
// Cuts the part of a 3-D track flown between two times at constant speed.
// ----------------------------------------------------------------------------
// Input channel: one vertex per item (point_x/y/z, final_vertex), taken when
// in_valid is high and in_stall is low. Output channel: slice points with
// has_point, slice_done, stop_index and zero_speed_error, handed over when
// out_valid is high and out_stall is low. Configuration goes through the APB
// port: begin_time at 0x0, end_time at 0x4, speed at 0x8.
// One vertex is worked on at a time. Segment length runs through a serial
// multiplier (three squares), a square root and a divider for flight time;
// each cut adds a fraction division and three serial products. Zero speed
// skips the flight-time division, and the first vertex of a track and
// ignored vertices skip the serial units altogether.
// Results sit in one output register, so the next vertex is taken while the
// last result waits; a stalled receiver holds the block at its next result.
// Reset clears the track state and loads begin 0, end 0, speed 1.0.
// ----------------------------------------------------------------------------
module polyline_time_slice #(
	parameter int unsigned MAX_POINTS = pts_pkg::MAX_POINTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// vertex input
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [31:0]         point_x,
	input  logic signed [31:0]         point_y,
	input  logic signed [31:0]         point_z,
	input  logic                       final_vertex,
	// slice output
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [31:0]         out_x,
	output logic signed [31:0]         out_y,
	output logic signed [31:0]         out_z,
	output logic                       has_point,
	output logic                       slice_done,
	output logic [10:0]                stop_index,
	output logic                       zero_speed_error,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [pts_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
	localparam int unsigned MW    = pts_pkg::MUL_W;
	localparam int unsigned DW    = pts_pkg::DIV_W;

	// configuration registers
	logic [31:0] begin_q, end_q, speed_q;
	logic        speed_zero;

	// track state
	logic [31:0]      prev_q [3];
	logic [31:0]      el_q;
	logic             inside_q;
	logic             fin_q;
	logic [CNT_W-1:0] vcnt_q;

	// current vertex and working registers
	logic [31:0] c_q [3];
	logic        last_q;
	logic [30:0] axs_q [3];
	logic [1:0]  sh_q;
	logic [1:0]  k_q;
	logic [63:0] sum_q;
	logic [33:0] len_q;
	logic [31:0] ttf_q;
	logic [31:0] at_q;
	logic        is_end_q;
	logic [29:0] f_q;
	logic [31:0] cut_q [3];

	// output register
	logic        out_valid_q;
	logic [31:0] ox_q, oy_q, oz_q;
	logic        ohas_q, odone_q, oerr_q;
	logic [10:0] ostop_q;
	logic        out_free;

	pts_pkg::st_t st_q, st_d;

	// serial units
	logic              mul_start, mul_done;
	logic [MW-1:0]     mul_a, mul_b;
	logic [2*MW-1:0]   mul_prod;
	logic              sqrt_start, sqrt_done;
	logic [31:0]       sqrt_root;
	logic              div_start, div_done;
	logic [DW-1:0]     div_dd, div_q;
	logic [31:0]       div_dv;

	// emit request
	logic        emit;
	logic [31:0] ex, ey, ez;
	logic        ehas, edone;
	logic [10:0] estop;

	// per-axis differences
	logic signed [32:0] d   [3];
	logic [32:0]        mg  [3];
	logic [32:0]        mx;
	logic [1:0]         sh;
	logic [32:0]        reach;
	logic               beg_hit, end_hit;
	logic [32:0]        off;
	logic [32:0]        lp_pt;
	logic               accept;

	assign speed_zero = speed_q == '0;
	assign pready     = 1'b1;
	assign accept     = in_valid && !in_stall;
	assign in_stall   = st_q != pts_pkg::ST_IDLE;
	assign out_free   = !out_valid_q || !out_stall;

	// ---------------- configuration port ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			begin_q <= '0;
			end_q   <= '0;
			speed_q <= pts_pkg::SPEED_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				pts_pkg::REG_BEGIN: begin_q <= pwdata;
				pts_pkg::REG_END:   end_q   <= pwdata;
				pts_pkg::REG_SPEED: speed_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			pts_pkg::REG_BEGIN: prdata = begin_q;
			pts_pkg::REG_END:   prdata = end_q;
			pts_pkg::REG_SPEED: prdata = speed_q;
			default:            prdata = '0;
		endcase
	end

	// ---------------- datapath helpers ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d[i]  = $signed({c_q[i][31], c_q[i]}) - $signed({prev_q[i][31], prev_q[i]});
			mg[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
		end
	end

	// pick the shift that brings the largest magnitude below 2^31
	always_comb begin
		mx = mg[0];
		if (mg[1] > mx) mx = mg[1];
		if (mg[2] > mx) mx = mg[2];
		if (mx[32])      sh = 2'd2;
		else if (mx[31]) sh = 2'd1;
		else             sh = 2'd0;
	end

	assign reach   = {1'b0, el_q} + {1'b0, ttf_q};
	assign beg_hit = !inside_q && (el_q <= begin_q) && (reach > {1'b0, begin_q});
	assign end_hit = inside_q && (el_q <= end_q) && (reach > {1'b0, end_q});

	// interpolated coordinate for the current axis
	assign off   = mul_prod[62:30];
	assign lp_pt = d[k_q][32] ? 33'({prev_q[k_q][31], prev_q[k_q]} - off)
	                          : 33'({prev_q[k_q][31], prev_q[k_q]} + off);

	// ---------------- sequencer: next state ----------------
	always_comb begin
		st_d = st_q;
		case (st_q)
			pts_pkg::ST_IDLE:  if (accept) st_d = pts_pkg::ST_CHK;
			pts_pkg::ST_CHK: begin
				if (fin_q)                    st_d = pts_pkg::ST_IDLE;
				else if (vcnt_q == '0)        st_d = last_q ? pts_pkg::ST_LAST
				                                            : pts_pkg::ST_IDLE;
				else                          st_d = pts_pkg::ST_SQ_GO;
			end
			pts_pkg::ST_SQ_GO: st_d = pts_pkg::ST_SQ_WT;
			pts_pkg::ST_SQ_WT: if (mul_done) st_d = (k_q == 2'd2) ? pts_pkg::ST_RT_GO
			                                                    : pts_pkg::ST_SQ_GO;
			pts_pkg::ST_RT_GO: st_d = pts_pkg::ST_RT_WT;
			pts_pkg::ST_RT_WT: if (sqrt_done) st_d = speed_zero ? pts_pkg::ST_PREV
			                                                    : pts_pkg::ST_TT_GO;
			pts_pkg::ST_TT_GO: st_d = pts_pkg::ST_TT_WT;
			pts_pkg::ST_TT_WT: if (div_done) st_d = pts_pkg::ST_PREV;
			pts_pkg::ST_PREV:  if (!inside_q || out_free) st_d = pts_pkg::ST_BEG;
			pts_pkg::ST_BEG:   st_d = beg_hit ? pts_pkg::ST_FR_GO : pts_pkg::ST_END;
			pts_pkg::ST_FR_GO: st_d = pts_pkg::ST_FR_WT;
			pts_pkg::ST_FR_WT: if (div_done) st_d = pts_pkg::ST_LP_GO;
			pts_pkg::ST_LP_GO: st_d = pts_pkg::ST_LP_WT;
			pts_pkg::ST_LP_WT: if (mul_done) st_d = (k_q == 2'd2) ? pts_pkg::ST_CUT
			                                                    : pts_pkg::ST_LP_GO;
			pts_pkg::ST_CUT:   if (out_free) st_d = is_end_q ? pts_pkg::ST_IDLE
			                                                 : pts_pkg::ST_END;
			pts_pkg::ST_END:   st_d = end_hit ? pts_pkg::ST_FR_GO : pts_pkg::ST_UPD;
			pts_pkg::ST_UPD:   st_d = last_q ? pts_pkg::ST_LAST : pts_pkg::ST_IDLE;
			pts_pkg::ST_LAST:  if (out_free) st_d = pts_pkg::ST_IDLE;
			default:           st_d = pts_pkg::ST_IDLE;
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	always_comb begin
		mul_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		div_dd     = '0;
		div_dv     = '0;
		emit       = 1'b0;
		ex         = '0;
		ey         = '0;
		ez         = '0;
		ehas       = 1'b0;
		edone      = 1'b0;
		estop      = '0;
		case (st_q)
			pts_pkg::ST_SQ_GO: begin
				mul_start = 1'b1;
				mul_a     = MW'(axs_q[k_q]);
				mul_b     = MW'(axs_q[k_q]);
			end
			pts_pkg::ST_RT_GO: sqrt_start = 1'b1;
			pts_pkg::ST_TT_GO: begin
				div_start = 1'b1;
				div_dd    = DW'({len_q, 16'h0000});
				div_dv    = speed_q;
			end
			pts_pkg::ST_FR_GO: begin
				div_start = 1'b1;
				div_dd    = DW'({32'(at_q - el_q), 30'h0});
				div_dv    = ttf_q;
			end
			pts_pkg::ST_LP_GO: begin
				mul_start = 1'b1;
				mul_a     = mg[k_q];
				mul_b     = MW'(f_q);
			end
			pts_pkg::ST_PREV: begin
				emit = inside_q;
				ex   = prev_q[0];
				ey   = prev_q[1];
				ez   = prev_q[2];
				ehas = 1'b1;
			end
			pts_pkg::ST_CUT: begin
				emit  = 1'b1;
				ex    = cut_q[0];
				ey    = cut_q[1];
				ez    = cut_q[2];
				ehas  = 1'b1;
				edone = is_end_q;
				estop = is_end_q ? 11'(vcnt_q) : '0;
			end
			pts_pkg::ST_LAST: begin
				emit  = 1'b1;
				ehas  = inside_q;
				ex    = inside_q ? c_q[0] : '0;
				ey    = inside_q ? c_q[1] : '0;
				ez    = inside_q ? c_q[2] : '0;
				edone = 1'b1;
				estop = 11'(vcnt_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= pts_pkg::ST_IDLE;
		else         st_q <= st_d;
	end

	// ---------------- track state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) prev_q[i] <= '0;
			el_q     <= '0;
			inside_q <= 1'b0;
			fin_q    <= 1'b0;
			vcnt_q   <= '0;
		end else begin
			case (st_q)
				pts_pkg::ST_CHK: begin
					if (fin_q) begin
						// drop vertices past the end cut
						if (last_q) begin
							for (int i = 0; i < 3; i++) prev_q[i] <= '0;
							el_q   <= '0;
							inside_q <= 1'b0;
							fin_q  <= 1'b0;
							vcnt_q <= '0;
						end
					end else if (vcnt_q == '0) begin
						for (int i = 0; i < 3; i++) prev_q[i] <= c_q[i];
						vcnt_q <= CNT_W'(1);
					end
				end
				pts_pkg::ST_CUT: begin
					if (out_free) begin
						if (!is_end_q) begin
							inside_q <= 1'b1;
						end else if (last_q) begin
							for (int i = 0; i < 3; i++) prev_q[i] <= '0;
							el_q     <= '0;
							inside_q <= 1'b0;
							vcnt_q   <= '0;
						end else begin
							fin_q <= 1'b1;
						end
					end
				end
				pts_pkg::ST_UPD: begin
					// advance to the next segment, elapsed time saturates
					el_q <= reach[32] ? pts_pkg::TIME_MAX : reach[31:0];
					for (int i = 0; i < 3; i++) prev_q[i] <= c_q[i];
					if (vcnt_q < CNT_W'(MAX_POINTS)) vcnt_q <= vcnt_q + 1'b1;
				end
				pts_pkg::ST_LAST: begin
					if (out_free) begin
						for (int i = 0; i < 3; i++) prev_q[i] <= '0;
						el_q     <= '0;
						inside_q <= 1'b0;
						fin_q    <= 1'b0;
						vcnt_q   <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// ---------------- working registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else begin
			case (st_q)
				pts_pkg::ST_CHK:   k_q <= '0;
				pts_pkg::ST_FR_WT: if (div_done) k_q <= '0;
				pts_pkg::ST_SQ_WT,
				pts_pkg::ST_LP_WT: if (mul_done) k_q <= k_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			pts_pkg::ST_IDLE: begin
				if (accept) begin
					c_q[0] <= point_x;
					c_q[1] <= point_y;
					c_q[2] <= point_z;
					last_q <= final_vertex;
				end
			end
			pts_pkg::ST_CHK: begin
				for (int i = 0; i < 3; i++) axs_q[i] <= 31'(mg[i] >> sh);
				sh_q  <= sh;
				sum_q <= '0;
			end
			pts_pkg::ST_SQ_WT: if (mul_done) sum_q <= sum_q + mul_prod[63:0];
			pts_pkg::ST_RT_WT: begin
				if (sqrt_done) begin
					len_q <= {2'b00, sqrt_root} << sh_q;
					if (speed_zero) ttf_q <= pts_pkg::TIME_MAX;
				end
			end
			pts_pkg::ST_TT_WT: begin
				if (div_done) begin
					ttf_q <= (div_q[DW-1:32] != '0) ? pts_pkg::TIME_MAX : div_q[31:0];
				end
			end
			pts_pkg::ST_BEG: begin
				at_q     <= begin_q;
				is_end_q <= 1'b0;
			end
			pts_pkg::ST_END: begin
				at_q     <= end_q;
				is_end_q <= 1'b1;
			end
			pts_pkg::ST_FR_WT: if (div_done) f_q <= div_q[29:0];
			pts_pkg::ST_LP_WT: if (mul_done) cut_q[k_q] <= lp_pt[31:0];
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			ox_q    <= ex;
			oy_q    <= ey;
			oz_q    <= ez;
			ohas_q  <= ehas;
			odone_q <= edone;
			ostop_q <= estop;
			oerr_q  <= speed_zero;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_x            = ox_q;
	assign out_y            = oy_q;
	assign out_z            = oz_q;
	assign has_point        = ohas_q;
	assign slice_done       = odone_q;
	assign stop_index       = ostop_q;
	assign zero_speed_error = oerr_q;

	// ---------------- serial units ----------------
	pts_mul #(.W(MW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	pts_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.n      (sum_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	pts_div #(.W(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dd),
		.divisor  (div_dv),
		.done     (div_done),
		.quot     (div_q)
	);

endmodule

FILE: sim/polyline_time_slice_tb.sv
// ----------------------------------------------------------------------------
// polyline_time_slice_tb
// Self-checking bench: tracks of vertices go in, slice points are predicted
// per vertex and compared field by field as they come out, under several
// time windows and speeds written through the APB port.
// ----------------------------------------------------------------------------
module polyline_time_slice_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned DRAIN_CYCLES = 700;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               last;
	} vertex_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               has;
		logic               done;
		logic [10:0]        stop;
		logic               zerr;
	} slice_pt_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall;
	logic signed [31:0] point_x, point_y, point_z;
	logic final_vertex;
	logic out_valid, out_stall;
	logic signed [31:0] out_x, out_y, out_z;
	logic has_point, slice_done, zero_speed_error;
	logic [10:0] stop_index;
	logic psel, penable, pwrite;
	logic [pts_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	polyline_time_slice dut (.*);

	// predictor state
	logic [31:0] win_begin, win_end, cfg_speed;
	logic signed [63:0] last_x, last_y, last_z;
	logic [31:0] fly_clock;
	logic in_cut, cut_closed;
	int unsigned seen_count;

	vertex_t vertex_q[$];
	slice_pt_t slice_q[$];
	int unsigned n_fail, n_items, n_results, n_done, cycles;
	bit feeding;
	bit in_taken;
	int unsigned burst_left, gap_left;

	// clock and timeout
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [63:0] mag64(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] n);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] segment_time(vertex_t v);
		logic [63:0] ax, ay, az, mx, len, q;
		int s;
		ax = mag64(64'(v.x) - last_x);
		ay = mag64(64'(v.y) - last_y);
		az = mag64(64'(v.z) - last_z);
		mx = ax > ay ? ax : ay;
		if (az > mx) mx = az;
		s = 0;
		while ((mx >> s) >= (64'd1 << 31)) s++;
		ax = ax >> s;
		ay = ay >> s;
		az = az >> s;
		len = root_floor(ax * ax + ay * ay + az * az) << s;
		if (cfg_speed == 0) return pts_pkg::TIME_MAX;
		q = (len << 16) / cfg_speed;
		return q > 64'(pts_pkg::TIME_MAX) ? pts_pkg::TIME_MAX : q[31:0];
	endfunction

	function automatic logic signed [31:0] blend(logic signed [63:0] a,
		logic signed [63:0] b, logic [63:0] f);
		logic signed [63:0] d;
		logic [63:0] off;
		d = b - a;
		off = (mag64(d) * f) >> 30;
		return d < 0 ? 32'(a - $signed(off)) : 32'(a + $signed(off));
	endfunction

	function automatic void push_point(logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] z, logic has, logic done, int unsigned stop);
		slice_pt_t p;
		p.x = has ? x : '0;
		p.y = has ? y : '0;
		p.z = has ? z : '0;
		p.has = has;
		p.done = done;
		p.stop = done ? stop[10:0] : '0;
		p.zerr = (cfg_speed == 0);
		slice_q.insert(slice_q.size(), p);
	endfunction

	function automatic void push_cut(vertex_t v, logic [31:0] at, logic [31:0] dur,
		logic done, int unsigned stop);
		logic [63:0] f;
		f = (64'(at - fly_clock) << 30) / dur;
		push_point(blend(last_x, v.x, f), blend(last_y, v.y, f),
			blend(last_z, v.z, f), 1'b1, done, stop);
	endfunction

	function automatic void reset_track();
		last_x = 0;
		last_y = 0;
		last_z = 0;
		fly_clock = 0;
		in_cut = 0;
		cut_closed = 0;
		seen_count = 0;
	endfunction

	// work out the slice points one vertex causes
	function automatic void predict_slice(vertex_t v);
		logic [31:0] dur;
		logic [63:0] reach;
		int unsigned idx;
		if (cut_closed) begin
			if (v.last) reset_track();
			return;
		end
		if (seen_count == 0) begin
			last_x = v.x;
			last_y = v.y;
			last_z = v.z;
			seen_count = 1;
			if (v.last) begin
				push_point(0, 0, 0, 1'b0, 1'b1, 1);
				reset_track();
			end
			return;
		end
		idx = seen_count;
		if (in_cut) push_point(last_x, last_y, last_z, 1'b1, 1'b0, 0);
		dur = segment_time(v);
		reach = 64'(fly_clock) + dur;
		if (!in_cut && fly_clock <= win_begin && reach > 64'(win_begin)) begin
			push_cut(v, win_begin, dur, 1'b0, 0);
			in_cut = 1;
		end
		if (in_cut && fly_clock <= win_end && reach > 64'(win_end)) begin
			push_cut(v, win_end, dur, 1'b1, idx);
			if (v.last) reset_track();
			else cut_closed = 1;
			return;
		end
		fly_clock = reach > 64'(pts_pkg::TIME_MAX) ? pts_pkg::TIME_MAX : reach[31:0];
		last_x = v.x;
		last_y = v.y;
		last_z = v.z;
		if (seen_count < pts_pkg::MAX_POINTS_DEF) seen_count++;
		if (v.last) begin
			push_point(v.x, v.y, v.z, in_cut, 1'b1, seen_count);
			reset_track();
		end
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
			n_results);
		n_fail++;
	endtask

	// driver: bursts of items with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// hold payload while stalled
		end else begin
			if (in_valid) begin
				void'(vertex_q.pop_front());
				n_items++;
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (feeding && vertex_q.size() > 0) begin
				in_valid <= 1'b1;
				point_x <= vertex_q[0].x;
				point_y <= vertex_q[0].y;
				point_z <= vertex_q[0].z;
				final_vertex <= vertex_q[0].last;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern: mostly open, with stretches of stalling
	always @(negedge clk) begin
		if (!arst_n) out_stall <= 1'b0;
		else if ((cycles / 2000) % 3 == 0) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(0, 3) == 0);
	end

	// monitor: predict on accepted items, check accepted results
	always @(posedge clk) begin
		slice_pt_t want;
		in_taken = arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_taken)
				predict_slice({point_x, point_y, point_z, final_vertex});
			if (out_valid && !out_stall) begin
				n_results++;
				if (slice_q.size() == 0) begin
					report_mismatch("unexpected result", out_x, '0);
				end else begin
					want = slice_q.pop_front();
					if (out_x !== want.x) report_mismatch("out_x", out_x, want.x);
					if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
					if (out_z !== want.z) report_mismatch("out_z", out_z, want.z);
					if (has_point !== want.has)
						report_mismatch("has_point", has_point, want.has);
					if (slice_done !== want.done)
						report_mismatch("slice_done", slice_done, want.done);
					if (slice_done) n_done++;
					if (stop_index !== want.stop)
						report_mismatch("stop_index", stop_index, want.stop);
					if (zero_speed_error !== want.zerr)
						report_mismatch("zero_speed_error", zero_speed_error, want.zerr);
				end
			end
		end
	end

	task automatic write_reg(logic [pts_pkg::ADDR_W-1:0] addr, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (addr)
			pts_pkg::REG_BEGIN: win_begin = value;
			pts_pkg::REG_END:   win_end = value;
			default:            cfg_speed = value;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_window(logic [31:0] b, logic [31:0] e, logic [31:0] s);
		write_reg(pts_pkg::REG_BEGIN, b);
		write_reg(pts_pkg::REG_END, e);
		write_reg(pts_pkg::REG_SPEED, s);
	endtask

	task automatic add_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic last);
		vertex_t v;
		v = {x, y, z, last};
		vertex_q.insert(vertex_q.size(), v);
	endtask

	// run queued items, wait for results, then let the block settle
	task automatic run_phase();
		feeding = 1;
		while (vertex_q.size() > 0 || in_valid) @(posedge clk);
		feeding = 0;
		while (slice_q.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// random coordinate: mostly small steps, sometimes full range
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom_range(0, 20 << 16) - (10 << 16);
		endcase
	endfunction

	// random track of len vertices, the last one marked final
	task automatic add_track(int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			add_vertex(rand_coord(), rand_coord(), rand_coord(), i == len - 1);
	endtask

	initial begin
		int unsigned len, total;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		final_vertex = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		feeding = 0;
		in_taken = 0;
		burst_left = 0;
		gap_left = 0;
		win_begin = 0;
		win_end = 0;
		cfg_speed = pts_pkg::SPEED_RST;
		reset_track();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset window, single vertex, extremes, zero-length segment
		add_vertex(32'h0001_0000, 0, 0, 1'b1);
		add_vertex(0, 0, 0, 1'b0);
		add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
		add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1);
		run_phase();
		set_window(32'h0001_0000, 32'h0005_0000, pts_pkg::SPEED_RST);
		add_vertex(0, 0, 0, 1'b0);
		add_vertex(0, 0, 0, 1'b0);
		add_vertex(32'h0003_0000, 0, 0, 1'b0);
		add_vertex(32'h0003_0000, 32'h0004_0000, 0, 1'b0);
		add_vertex(32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000, 1'b0);
		add_vertex(32'h0010_0000, 0, 0, 1'b1);
		add_vertex(0, 0, 0, 1'b0);
		add_vertex(32'h0000_8000, 0, 0, 1'b1);
		run_phase();
		// end never reached, and zero speed
		set_window(0, pts_pkg::TIME_MAX, 32'h0000_8000);
		add_vertex(32'hFFFF_0000, 0, 0, 1'b0);
		add_vertex(32'h0002_0000, 32'h0001_0000, 0, 1'b0);
		add_vertex(32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
		run_phase();
		set_window(32'h0000_1000, pts_pkg::TIME_MAX, 0);
		add_vertex(0, 0, 0, 1'b0);
		add_vertex(32'h0001_0000, 0, 0, 1'b0);
		add_vertex(32'h0002_0000, 0, 0, 1'b1);
		run_phase();
		set_window(pts_pkg::TIME_MAX, pts_pkg::TIME_MAX, pts_pkg::TIME_MAX);
		add_vertex(32'h8000_0000, 0, 32'h7FFF_FFFF, 1'b0);
		add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1);
		run_phase();

		// random phases over a range of windows and speeds
		total = 0;
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 5)
				0: set_window($urandom_range(0, 8 << 16), $urandom_range(4 << 16, 60 << 16),
					pts_pkg::SPEED_RST);
				1: set_window($urandom_range(0, 2 << 16), $urandom(), $urandom_range(1, 4 << 16));
				2: set_window($urandom(), $urandom(), $urandom());
				3: set_window(0, $urandom_range(0, 30 << 16), $urandom_range(0, 1) ? 1 : 0);
				default: set_window($urandom_range(1 << 16, 10 << 16),
					$urandom_range(10 << 16, 40 << 16), $urandom_range(1 << 15, 3 << 16));
			endcase
			for (int unsigned n = 0; n < 85; n += len) begin
				len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
				add_track(len);
			end
			total += vertex_q.size();
			run_phase();
		end

		$display("covered %0d vertices (%0d random), %0d slice points, %0d slices closed",
			n_items, total, n_results, n_done);
		if (n_fail == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", n_fail);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
